@@ rtl/lwwr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the last-writer-wins register replicator.
// Used by the controller, the datapath, the top level and the checker.
package lwwr_pkg;

    localparam int NODE_W  = 5;
    localparam int BOARD_W = 4;
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 32;
    localparam int VAL_W   = 16;
    localparam int QP_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 168;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_INDEX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_BASE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LENGTH = 3'd4;

    localparam logic MODE_LOCAL  = 1'b0;
    localparam logic MODE_PEER   = 1'b1;
    localparam logic KIND_DESC   = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 5'd2;
    localparam logic [NODE_W-1:0] NODE_COUNT_MIN   = 5'd2;
    localparam logic [LEN_W-1:0]  LENGTH_RESET     = 32'd4;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    typedef struct packed {
        logic take_peer;
        logic take_query;
        logic take_write;
        logic emit_desc;
    } lwwr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_peer;
        logic in_query;
        logic desc_final;
    } lwwr_status_t;

endpackage

@@ rtl/lwwr_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: accepts requests and sequences descriptor output.
// Depends on lwwr_pkg; drives commands into lwwr_dp.
module lwwr_ctrl
    import lwwr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  lwwr_status_t status,
    output lwwr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.in_peer)
                    begin
                        cmd.take_peer = 1'b1;
                    end
                    else if (status.in_query)
                    begin
                        cmd.take_query = 1'b1;
                    end
                    else
                    begin
                        cmd.take_write = 1'b1;
                        state_next     = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_desc = 1'b1;
                    if (status.desc_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/lwwr_dp.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, the replicated register and the output stage.
// Depends on lwwr_pkg; commanded by lwwr_ctrl.
module lwwr_dp
    import lwwr_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  lwwr_cmd_t             cmd,
    output lwwr_status_t          status
);

    localparam logic [NODE_W:0] NODE_CAP =
        (MAX_NODES > 31) ? 6'd31 : 6'(MAX_NODES);

    logic [NODE_W-1:0]  node_count_reg;
    logic [BOARD_W-1:0] board_index_reg;
    logic [ADDR_W-1:0]  local_address_reg;
    logic [ADDR_W-1:0]  remote_base_reg;
    logic [LEN_W-1:0]   transfer_length_reg;

    logic [VAL_W-1:0]   value_reg;
    logic [VAL_W-1:0]   stamp_reg;

    logic [NODE_W-1:0]  count_reg;
    logic [NODE_W-1:0]  k_reg;
    logic [QP_W-1:0]    qp_base_reg;
    logic [ADDR_W-1:0]  raddr_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic               out_last_reg;
    logic [QP_W-1:0]    out_qp_reg;
    logic [ADDR_W-1:0]  out_local_reg;
    logic [ADDR_W-1:0]  out_remote_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [VAL_W-1:0]   out_value_reg;
    logic [VAL_W-1:0]   out_stamp_reg;

    logic [VAL_W-1:0]   op_value;
    logic [BOARD_W-1:0] peer_index;
    logic [VAL_W-1:0]   peer_value;
    logic [VAL_W-1:0]   peer_stamp;
    logic [NODE_W-1:0]  nodes;
    logic [NODE_W-1:0]  peers;
    logic [NODE_W+BOARD_W-1:0] qp_product;
    logic               peer_wins;

    assign op_value   = s_tdata[15:0];
    assign peer_index = s_tdata[19:16];
    assign peer_value = s_tdata[35:20];
    assign peer_stamp = s_tdata[51:36];

    always_comb
    begin
        if (node_count_reg < NODE_COUNT_MIN)
        begin
            nodes = NODE_COUNT_MIN;
        end
        else if ({1'b0, node_count_reg} > NODE_CAP)
        begin
            nodes = NODE_CAP[NODE_W-1:0];
        end
        else
        begin
            nodes = node_count_reg;
        end
    end

    assign peers      = nodes - 5'd1;
    assign qp_product = board_index_reg * peers;
    assign peer_wins  = (peer_index != board_index_reg) &&
                        ({1'b0, peer_index} < nodes) &&
                        (peer_stamp > stamp_reg);

    assign status.out_free   = !out_valid_reg || m_tready;
    assign status.in_peer    = (s_tuser == MODE_PEER);
    assign status.in_query   = (op_value == '0);
    assign status.desc_final = (k_reg == count_reg - 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg      <= NODE_COUNT_RESET;
            board_index_reg     <= '0;
            local_address_reg   <= '0;
            remote_base_reg     <= '0;
            transfer_length_reg <= LENGTH_RESET;
            value_reg           <= '0;
            stamp_reg           <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT:      node_count_reg      <= cfg_data[NODE_W-1:0];
                    CFG_BOARD_INDEX:     board_index_reg     <= cfg_data[BOARD_W-1:0];
                    CFG_LOCAL_ADDRESS:   local_address_reg   <= cfg_data;
                    CFG_REMOTE_BASE:     remote_base_reg     <= cfg_data;
                    CFG_TRANSFER_LENGTH: transfer_length_reg <= cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.take_peer && peer_wins)
            begin
                value_reg <= peer_value;
                stamp_reg <= peer_stamp;
            end
            if (cmd.take_write)
            begin
                value_reg <= op_value;
                stamp_reg <= stamp_reg + 16'd1;
            end
            if (cmd.take_query || cmd.emit_desc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_write)
        begin
            count_reg   <= peers;
            k_reg       <= '0;
            qp_base_reg <= qp_product[QP_W-1:0];
            raddr_reg   <= remote_base_reg + {{(ADDR_W-BOARD_W-2){1'b0}}, board_index_reg, 2'b00};
        end
        else if (cmd.emit_desc)
        begin
            k_reg <= k_reg + 5'd1;
        end

        if (cmd.take_query)
        begin
            out_kind_reg   <= KIND_ANSWER;
            out_last_reg   <= 1'b1;
            out_qp_reg     <= '0;
            out_local_reg  <= '0;
            out_remote_reg <= '0;
            out_len_reg    <= '0;
            out_value_reg  <= value_reg;
            out_stamp_reg  <= stamp_reg;
        end
        else if (cmd.emit_desc)
        begin
            out_kind_reg   <= KIND_DESC;
            out_last_reg   <= status.desc_final;
            out_qp_reg     <= qp_base_reg + {{(QP_W-NODE_W){1'b0}}, k_reg};
            out_local_reg  <= local_address_reg;
            out_remote_reg <= raddr_reg;
            out_len_reg    <= transfer_length_reg;
            out_value_reg  <= value_reg;
            out_stamp_reg  <= stamp_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_stamp_reg, out_value_reg, out_len_reg,
                       out_remote_reg, out_local_reg, out_qp_reg};

endmodule

@@ rtl/lww_register_replicator_top.sv @@
`timescale 1ns / 1ps
// A query answer is presented in the cycle after its request is accepted. A write
// enters the emit state, which registers one descriptor per cycle while the output is
// free and holds the input until the last of them, node count minus one in all (node
// count capped at MAX_NODES and 31). Peer words and queries do not hold the input.
// Reset clears the register to zero and restores configuration defaults at once.
module lww_register_replicator_top
    import lwwr_pkg::*;
#(
    parameter int MAX_NODES = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // op_value[15:0], peer_index[19:16], peer_value[35:20], peer_stamp[51:36], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // queue_pair[7:0], dest_local_address[55:8], dest_remote_address[103:56],
    // transfer_bytes[135:104], value_out[151:136], stamp_out[167:152]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic                  m_tuser,
    output logic                  m_tlast
);

    lwwr_cmd_t    cmd;
    lwwr_status_t status;

    assign cfg_ready = 1'b1;

    lwwr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lwwr_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/lwwr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the replicator, bound to the top level.
// Depends on lwwr_pkg and lww_register_replicator_top.
module lwwr_checker
    import lwwr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Result request changed while stalled.");

    a_answer_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ANSWER) |-> m_tlast && (m_tdata[135:0] == '0))
        else $error("Query answer is not a single request with zeroed descriptor fields.");

    a_desc_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tuser == KIND_DESC) &&
            (m_tdata[7:0] == $past(m_tdata[7:0]) + 8'd1))
        else $error("Descriptor run broken or queue pair not consecutive.");

    a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("Input taken while a descriptor run is in progress.");

endmodule

bind lww_register_replicator_top lwwr_checker u_lwwr_checker (.*);
